FILE: design/camera_image_packet_receiver_core_defines.svh
// Assertion macros shared by the checker of the packet receiver.
`ifndef CAMERA_IMAGE_PACKET_RECEIVER_CORE_DEFINES_SVH
`define CAMERA_IMAGE_PACKET_RECEIVER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CIPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CIPR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/cipr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cipr_pkg;

	localparam int PACKET_BYTES = 512;
	localparam int PAYLOAD_MAX  = PACKET_BYTES - 6;

	localparam logic [1:0] OP_START   = 2'd0;
	localparam logic [1:0] OP_BYTE    = 2'd1;
	localparam logic [1:0] OP_IDLE    = 2'd2;
	localparam logic [1:0] OP_TIMEOUT = 2'd3;

	localparam logic [2:0] KIND_TX       = 3'd0;
	localparam logic [2:0] KIND_IMAGE    = 3'd1;
	localparam logic [2:0] KIND_ACCEPTED = 3'd2;
	localparam logic [2:0] KIND_COMPLETE = 3'd3;
	localparam logic [2:0] KIND_ERROR    = 3'd4;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_TIMEOUT = 3'd1;
	localparam logic [2:0] ERR_BUFFER  = 3'd2;
	localparam logic [2:0] ERR_RETRIES = 3'd3;
	localparam logic [2:0] ERR_NO_DATA = 3'd4;

	localparam logic [2:0] CMD_ERROR    = 3'd0;
	localparam logic [2:0] CMD_DATA     = 3'd1;
	localparam logic [2:0] CMD_REQUEST  = 3'd2;
	localparam logic [2:0] CMD_ACC_NEXT = 3'd3;
	localparam logic [2:0] CMD_ACC_DONE = 3'd4;

	localparam logic [0:0] REG_OUT_BUFFER_SIZE = 1'd0;
	localparam logic [0:0] REG_RETRY_LIMIT     = 1'd1;

	localparam logic [7:0] FRAME_SYNC = 8'hAA;
	localparam logic [7:0] FRAME_CMD  = 8'h0E;
	localparam logic [7:0] ACK_BYTE   = 8'hF0;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  rx_byte;
		logic [23:0] image_length;
	} cipr_in_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  value;
		logic [15:0] packet_id;
		logic [8:0]  kept_count;
		logic [2:0]  error_code;
		logic        last;
	} cipr_out_t;

	typedef struct packed {
		logic [2:0]  code;
		logic [15:0] id;
		logic [8:0]  kept;
		logic [7:0]  value;
		logic [2:0]  err;
	} cipr_cmd_t;

	function automatic logic [7:0] frame_byte(input logic [2:0] idx, input logic [7:0] p2,
		input logic [7:0] p3);
		logic [7:0] b;
		case (idx)
			3'd0: b = FRAME_SYNC;
			3'd1: b = FRAME_CMD;
			3'd4: b = p2;
			3'd5: b = p3;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

FILE: design/cipr_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module cipr_cmd_fifo import cipr_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  cipr_cmd_t wr_data,
	output logic      full,
	input  logic      rd_en,
	output cipr_cmd_t rd_data,
	output logic      not_empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cipr_cmd_t            mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

FILE: design/cipr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cipr_front import cipr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  cipr_in_t   item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data,
	output logic       cmd_valid,
	output cipr_cmd_t  cmd,
	input  logic       cmd_full
);
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_DATA   = 3'd2;
	localparam logic [2:0] PH_VERIFY = 3'd3;
	localparam logic [2:0] PH_DRAIN  = 3'd4;

	logic [2:0]  phase_q, phase_n;
	logic [15:0] cur_pkt_q, cur_pkt_n;
	logic [23:0] remain_q, remain_n;
	logic [2:0]  attempt_q, attempt_n;
	logic [8:0]  pos_q, pos_n;
	logic [8:0]  psize_q, psize_n;
	logic [7:0]  low_q, low_n;
	logic [7:0]  sum_q, sum_n;
	logic [8:0]  keep_q, keep_n;
	logic [8:0]  obuf_q;
	logic [2:0]  rlimit_q;

	logic        accept;
	logic [15:0] size;
	logic [7:0]  sum_add;
	logic [9:0]  pos_inc;

	assign accept    = push && !cmd_full;
	assign full      = cmd_full;
	assign cfg_ready = 1'b1;
	assign size      = {item.rx_byte, low_q};
	assign sum_add   = sum_q + item.rx_byte;
	assign pos_inc   = {1'b0, pos_q} + 10'd1;

	always_comb begin
		phase_n   = phase_q;
		cur_pkt_n = cur_pkt_q;
		remain_n  = remain_q;
		attempt_n = attempt_q;
		pos_n     = pos_q;
		psize_n   = psize_q;
		low_n     = low_q;
		sum_n     = sum_q;
		keep_n    = keep_q;
		cmd_valid = 1'b0;
		cmd.code  = CMD_ERROR;
		cmd.id    = cur_pkt_q;
		cmd.kept  = '0;
		cmd.value = '0;
		cmd.err   = ERR_NONE;
		case (item.op)
			OP_START: begin
				cur_pkt_n = '0;
				cmd.id    = '0;
				cmd_valid = 1'b1;
				if (item.image_length == '0) begin
					remain_n = '0;
					phase_n  = PH_IDLE;
					cmd.err  = ERR_NO_DATA;
				end else begin
					remain_n  = item.image_length;
					attempt_n = 3'd1;
					phase_n   = PH_HEADER;
					pos_n     = '0;
					sum_n     = '0;
					cmd.code  = CMD_REQUEST;
				end
			end
			OP_BYTE: begin
				case (phase_q)
					PH_HEADER: begin
						sum_n = sum_add;
						if (pos_q == 9'd3) begin
							if (size == '0 || size > 16'(PAYLOAD_MAX)) begin
								phase_n = PH_DRAIN;
							end else if (size > {7'd0, obuf_q}) begin
								phase_n   = PH_IDLE;
								cmd_valid = 1'b1;
								cmd.err   = ERR_BUFFER;
							end else begin
								psize_n = size[8:0];
								keep_n  = ({8'd0, size} < remain_q) ? size[8:0] : remain_q[8:0];
								pos_n   = '0;
								phase_n = PH_DATA;
							end
						end else begin
							if (pos_q == 9'd2) begin
								low_n = item.rx_byte;
							end
							pos_n = pos_inc[8:0];
						end
					end
					PH_DATA: begin
						sum_n = sum_add;
						if (pos_q < keep_q) begin
							cmd_valid = 1'b1;
							cmd.code  = CMD_DATA;
							cmd.value = item.rx_byte;
						end
						if (pos_inc >= {1'b0, psize_q}) begin
							pos_n   = '0;
							phase_n = PH_VERIFY;
						end else begin
							pos_n = pos_inc[8:0];
						end
					end
					PH_VERIFY: begin
						if (pos_q == '0) begin
							low_n = item.rx_byte;
							pos_n = 9'd1;
						end else if (low_q != sum_q) begin
							phase_n = PH_DRAIN;
						end else begin
							cmd_valid = 1'b1;
							cmd.kept  = keep_q;
							cur_pkt_n = cur_pkt_q + 16'd1;
							remain_n  = remain_q - {15'd0, keep_q};
							if (remain_n == '0) begin
								cmd.code = CMD_ACC_DONE;
								phase_n  = PH_IDLE;
							end else begin
								cmd.code  = CMD_ACC_NEXT;
								attempt_n = 3'd1;
								phase_n   = PH_HEADER;
								pos_n     = '0;
								sum_n     = '0;
							end
						end
					end
					default: begin
					end
				endcase
			end
			OP_IDLE: begin
				if (phase_q == PH_DRAIN) begin
					cmd_valid = 1'b1;
					if (attempt_q >= rlimit_q) begin
						phase_n = PH_IDLE;
						cmd.err = ERR_RETRIES;
					end else begin
						attempt_n = attempt_q + 3'd1;
						phase_n   = PH_HEADER;
						pos_n     = '0;
						sum_n     = '0;
						cmd.code  = CMD_REQUEST;
					end
				end
			end
			default: begin
				if (phase_q != PH_IDLE) begin
					phase_n   = PH_IDLE;
					cmd_valid = 1'b1;
					cmd.err   = ERR_TIMEOUT;
				end
			end
		endcase
		cmd_valid = cmd_valid && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			cur_pkt_q <= '0;
			remain_q  <= '0;
			attempt_q <= '0;
			pos_q     <= '0;
			psize_q   <= '0;
			low_q     <= '0;
			sum_q     <= '0;
			keep_q    <= '0;
			obuf_q    <= 9'd506;
			rlimit_q  <= 3'd3;
		end else begin
			if (accept) begin
				phase_q   <= phase_n;
				cur_pkt_q <= cur_pkt_n;
				remain_q  <= remain_n;
				attempt_q <= attempt_n;
				pos_q     <= pos_n;
				psize_q   <= psize_n;
				low_q     <= low_n;
				sum_q     <= sum_n;
				keep_q    <= keep_n;
			end
			if (cfg_valid) begin
				if (cfg_index == REG_OUT_BUFFER_SIZE) begin
					obuf_q <= cfg_data;
				end else begin
					rlimit_q <= cfg_data[2:0];
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: design/cipr_back.sv
`timescale 1ns / 1ps
`default_nettype none
module cipr_back import cipr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  cipr_cmd_t head,
	output logic      head_pop,
	output logic      empty,
	input  logic      pop,
	output cipr_out_t result
);
	logic [2:0] step_q;
	logic       out_valid_q;
	cipr_out_t  res_q;
	cipr_out_t  res_n;
	logic [2:0] last_step;
	logic       advance;
	logic [15:0] next_id;
	logic [2:0]  fidx;

	assign next_id = head.id + 16'd1;
	assign fidx    = step_q - 3'd1;
	assign advance = head_valid && (!out_valid_q || pop);
	assign head_pop = advance && (step_q == last_step);
	assign empty   = !out_valid_q;
	assign result  = res_q;

	always_comb begin
		res_n.kind       = KIND_TX;
		res_n.value      = '0;
		res_n.packet_id  = head.id;
		res_n.kept_count = '0;
		res_n.error_code = ERR_NONE;
		case (head.code)
			CMD_ERROR: begin
				last_step        = 3'd0;
				res_n.kind       = KIND_ERROR;
				res_n.error_code = head.err;
			end
			CMD_DATA: begin
				last_step   = 3'd0;
				res_n.kind  = KIND_IMAGE;
				res_n.value = head.value;
			end
			CMD_REQUEST: begin
				last_step   = 3'd5;
				res_n.value = frame_byte(step_q, head.id[7:0], head.id[15:8]);
			end
			CMD_ACC_NEXT: begin
				last_step = 3'd6;
				if (step_q == '0) begin
					res_n.kind       = KIND_ACCEPTED;
					res_n.kept_count = head.kept;
				end else begin
					res_n.packet_id = next_id;
					res_n.value     = frame_byte(fidx, next_id[7:0], next_id[15:8]);
				end
			end
			default: begin
				last_step = 3'd7;
				if (step_q == '0) begin
					res_n.kind       = KIND_ACCEPTED;
					res_n.kept_count = head.kept;
				end else if (step_q == 3'd7) begin
					res_n.kind = KIND_COMPLETE;
				end else begin
					res_n.value = frame_byte(fidx, ACK_BYTE, ACK_BYTE);
				end
			end
		endcase
		res_n.last = (step_q == last_step);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				step_q      <= head_pop ? '0 : step_q + 3'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

FILE: design/camera_image_packet_receiver_core.sv
// Camera image packet receiver.
// Input items arrive on a queue-style port: an item is taken on a clock edge with
// push high and full low. Results leave on a queue-style port: the oldest result is
// on the result port while empty is low and is taken on an edge with pop high.
// Registers are written over the configuration port, which is always ready.
// A transaction enters the front, which updates the packet parser and queues at most
// one compact command. The back expands each command into one to eight results, one
// per cycle while the output register is empty or being popped, into that register.
// With the queue and output register empty, an accepted item's command is written
// into the queue and its first result is then registered into the output register.
// Items that cause zero or one result are taken every cycle while the command queue
// is not full; an item that causes several results holds the back while they leave,
// and the front keeps taking items until the CMD_DEPTH-entry command queue is full.
// When the receiver stops popping, the output register holds its result, the back
// stops, the queue fills and full is raised.
// Reset leaves the parser idle, the queue and output empty, out_buffer_size at 506
// and retry_limit at 3.
`timescale 1ns / 1ps
`default_nettype none
module camera_image_packet_receiver_core import cipr_pkg::*; #(
	parameter int CMD_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  cipr_in_t   item,
	output logic       empty,
	input  logic       pop,
	output cipr_out_t  result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data
);
	logic      cmd_valid;
	cipr_cmd_t cmd;
	logic      cmd_full;
	logic      head_valid;
	cipr_cmd_t head;
	logic      head_pop;

	cipr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_full  (cmd_full)
	);

	cipr_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cmd_valid),
		.wr_data   (cmd),
		.full      (cmd_full),
		.rd_en     (head_pop),
		.rd_data   (head),
		.not_empty (head_valid)
	);

	cipr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);
endmodule
`default_nettype wire

FILE: design/cipr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "camera_image_packet_receiver_core_defines.svh"
module cipr_checker import cipr_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      empty,
	input logic      pop,
	input cipr_out_t result
);
	`CIPR_ASSERT_NXT(a_result_holds, clk, arst_n, !empty && !pop, !empty && $stable(result), "stalled result changed")
	`CIPR_ASSERT_IMP(a_value_zero, clk, arst_n, !empty && result.kind != KIND_TX && result.kind != KIND_IMAGE, result.value == 8'd0, "value set on a status result")
	`CIPR_ASSERT_IMP(a_error_code, clk, arst_n, !empty, (result.kind == KIND_ERROR) == (result.error_code != ERR_NONE), "error code does not match kind")
	`CIPR_ASSERT_IMP(a_kept_count, clk, arst_n, !empty && result.kind != KIND_ACCEPTED, result.kept_count == 9'd0, "kept count outside an accepted packet")
endmodule

bind camera_image_packet_receiver_core cipr_checker u_cipr_checker (.*);
`default_nettype wire

FILE: tb/sv/camera_image_packet_receiver_core_tb.sv
`timescale 1ns / 1ps
module camera_image_packet_receiver_core_tb;
	import cipr_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS = 56;

	typedef enum logic [2:0] {
		WAIT_START,
		IN_HEADER,
		IN_DATA,
		IN_VERIFY,
		DRAINING
	} rx_phase_t;

	class camera_link_tracker;
		logic [8:0]  buf_limit;
		logic [2:0]  retry_cap;
		rx_phase_t   ph;
		logic [15:0] pkt_id;
		logic [23:0] remaining;
		logic [2:0]  attempts;
		logic [9:0]  pos;
		logic [8:0]  pay_size;
		logic [7:0]  size_lo;
		logic [7:0]  sum;
		logic [8:0]  keep;
		cipr_out_t   awaited[$];
		int          errors;

		function new();
			buf_limit = 9'd506;
			retry_cap = 3'd3;
			ph = WAIT_START;
			pkt_id = '0;
			remaining = '0;
			attempts = '0;
			pos = '0;
			pay_size = '0;
			size_lo = '0;
			sum = '0;
			keep = '0;
			errors = 0;
		endfunction

		function void set_register(logic idx, logic [8:0] data);
			if (idx == REG_OUT_BUFFER_SIZE) begin
				buf_limit = data;
			end else begin
				retry_cap = data[2:0];
			end
		endfunction

		function void add(logic [2:0] k, logic [7:0] v, logic [15:0] id, logic [8:0] kept,
			logic [2:0] err);
			cipr_out_t r;
			r.kind = k;
			r.value = v;
			r.packet_id = id;
			r.kept_count = kept;
			r.error_code = err;
			r.last = 1'b0;
			awaited.push_back(r);
		endfunction

		function void queue_command_bytes(logic [7:0] p2, logic [7:0] p3, logic [15:0] id);
			add(KIND_TX, FRAME_SYNC, id, 9'd0, ERR_NONE);
			add(KIND_TX, FRAME_CMD, id, 9'd0, ERR_NONE);
			add(KIND_TX, 8'h00, id, 9'd0, ERR_NONE);
			add(KIND_TX, 8'h00, id, 9'd0, ERR_NONE);
			add(KIND_TX, p2, id, 9'd0, ERR_NONE);
			add(KIND_TX, p3, id, 9'd0, ERR_NONE);
		endfunction

		function void ask_for_packet();
			ph = IN_HEADER;
			pos = '0;
			sum = '0;
			queue_command_bytes(pkt_id[7:0], pkt_id[15:8], pkt_id);
		endfunction

		function void abort_transfer(logic [2:0] code);
			ph = WAIT_START;
			add(KIND_ERROR, 8'h00, pkt_id, 9'd0, code);
		endfunction

		function void parse_byte(logic [7:0] b);
			logic [15:0] sz;
			logic [15:0] done_id;
			case (ph)
				IN_HEADER: begin
					sum = sum + b;
					if (pos == 10'd3) begin
						sz = {b, size_lo};
						if (sz == 16'd0 || sz > PAYLOAD_MAX) begin
							ph = DRAINING;
							return;
						end
						if (sz > buf_limit) begin
							abort_transfer(ERR_BUFFER);
							return;
						end
						pay_size = sz[8:0];
						keep = (sz < remaining) ? sz[8:0] : remaining[8:0];
						pos = '0;
						ph = IN_DATA;
						return;
					end
					if (pos == 10'd2) begin
						size_lo = b;
					end
					pos = pos + 10'd1;
				end
				IN_DATA: begin
					sum = sum + b;
					if (pos < keep) begin
						add(KIND_IMAGE, b, pkt_id, 9'd0, ERR_NONE);
					end
					pos = pos + 10'd1;
					if (pos >= pay_size) begin
						pos = '0;
						ph = IN_VERIFY;
					end
				end
				IN_VERIFY: begin
					if (pos == 10'd0) begin
						size_lo = b;
						pos = 10'd1;
						return;
					end
					if (size_lo != sum) begin
						ph = DRAINING;
						return;
					end
					done_id = pkt_id;
					add(KIND_ACCEPTED, 8'h00, done_id, keep, ERR_NONE);
					pkt_id = pkt_id + 16'd1;
					remaining = remaining - keep;
					if (remaining == 24'd0) begin
						queue_command_bytes(ACK_BYTE, ACK_BYTE, done_id);
						add(KIND_COMPLETE, 8'h00, done_id, 9'd0, ERR_NONE);
						ph = WAIT_START;
					end else begin
						attempts = 3'd1;
						ask_for_packet();
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void take_item(cipr_in_t it);
			int first;
			cipr_out_t r;
			first = awaited.size();
			case (it.op)
				OP_START: begin
					pkt_id = '0;
					if (it.image_length == 24'd0) begin
						remaining = '0;
						abort_transfer(ERR_NO_DATA);
					end else begin
						remaining = it.image_length;
						attempts = 3'd1;
						ask_for_packet();
					end
				end
				OP_BYTE: parse_byte(it.rx_byte);
				OP_IDLE: begin
					if (ph == DRAINING) begin
						if (attempts >= retry_cap) begin
							abort_transfer(ERR_RETRIES);
						end else begin
							attempts = attempts + 3'd1;
							ask_for_packet();
						end
					end
				end
				default: begin
					if (ph != WAIT_START) begin
						abort_transfer(ERR_TIMEOUT);
					end
				end
			endcase
			if (awaited.size() > first) begin
				r = awaited.pop_back();
				r.last = 1'b1;
				awaited.push_back(r);
			end
		endfunction

		function void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			errors++;
		endfunction

		function void check_result(cipr_out_t got);
			cipr_out_t want;
			if (awaited.size() == 0) begin
				$display("%0t: result with nothing expected, actual kind %0h value %0h id %0h",
					$time, got.kind, got.value, got.packet_id);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.kind !== want.kind) note_mismatch("kind", want.kind, got.kind);
			if (got.value !== want.value) note_mismatch("value", want.value, got.value);
			if (got.packet_id !== want.packet_id)
				note_mismatch("packet_id", want.packet_id, got.packet_id);
			if (got.kept_count !== want.kept_count)
				note_mismatch("kept_count", want.kept_count, got.kept_count);
			if (got.error_code !== want.error_code)
				note_mismatch("error_code", want.error_code, got.error_code);
			if (got.last !== want.last) note_mismatch("last", want.last, got.last);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	cipr_in_t   item = '0;
	logic       empty;
	logic       pop = 1'b0;
	cipr_out_t  result;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_index = 1'b0;
	logic [8:0] cfg_data = '0;

	camera_link_tracker link;
	int items_sent = 0;
	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;
	bit hold_request = 1'b0;

	camera_image_packet_receiver_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	task automatic send_item(cipr_in_t it);
		int gap;
		if (items_sent % 50 == 0) tx_idle = ($urandom_range(0, 2) != 0);
		gap = tx_idle ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		push <= 1'b1;
		do begin
			@(posedge clk);
		end while (full !== 1'b0);
		link.take_item(it);
		items_sent++;
	endtask

	task automatic send_byte(logic [7:0] b);
		cipr_in_t it;
		it.op = OP_BYTE;
		it.rx_byte = b;
		it.image_length = 24'($urandom);
		send_item(it);
	endtask

	task automatic send_start(logic [23:0] len);
		cipr_in_t it;
		it.op = OP_START;
		it.rx_byte = 8'($urandom);
		it.image_length = len;
		send_item(it);
	endtask

	task automatic send_event(logic [1:0] op);
		cipr_in_t it;
		it.op = op;
		it.rx_byte = 8'($urandom);
		it.image_length = 24'($urandom);
		send_item(it);
	endtask

	task automatic send_packet(logic [15:0] size_field, int data_count, bit corrupt);
		logic [7:0] sum;
		logic [7:0] b;
		int i;
		sum = '0;
		repeat (2) begin
			b = 8'($urandom);
			sum = sum + b;
			send_byte(b);
		end
		sum = sum + size_field[7:0] + size_field[15:8];
		send_byte(size_field[7:0]);
		send_byte(size_field[15:8]);
		for (i = 0; i < data_count; i++) begin
			b = 8'($urandom);
			sum = sum + b;
			send_byte(b);
		end
		send_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
		send_byte(8'($urandom));
	endtask

	task automatic run_transfer();
		int r;
		int pkts;
		int sz;
		int cap;
		int k;
		int i;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			send_start(24'd0);
		end else if (r == 1) begin
			send_start(24'($urandom_range(1, 24'hFFFFFF)));
		end else begin
			send_start(24'($urandom_range(1, 40)));
		end
		pkts = 0;
		while (link.ph == IN_HEADER && pkts < 10) begin
			pkts++;
			cap = (link.buf_limit < 16) ? link.buf_limit : 16;
			sz = $urandom_range(1, cap);
			r = $urandom_range(0, 99);
			if (r < 66) begin
				send_packet(16'(sz), sz, 1'b0);
			end else if (r < 76) begin
				send_packet(16'(sz), sz, 1'b1);
				send_event(OP_IDLE);
			end else if (r < 84) begin
				sz = r[0] ? 0 : $urandom_range(PAYLOAD_MAX + 1, 16'hFFFF);
				send_packet(16'(sz), $urandom_range(0, 3), 1'b0);
				send_event(r < 82 ? OP_IDLE : OP_TIMEOUT);
			end else if (r < 89) begin
				// A packet cut short in the header, data or verify bytes.
				k = $urandom_range(0, 13);
				for (i = 0; i < k; i++) begin
					send_byte(i == 2 ? 8'd8 : i == 3 ? 8'd0 : 8'($urandom));
				end
				send_event(OP_TIMEOUT);
			end else if (r < 93) begin
				send_event(OP_IDLE);
			end else if (r < 97 && link.buf_limit < PAYLOAD_MAX) begin
				send_packet(16'($urandom_range(link.buf_limit + 1, PAYLOAD_MAX)), 2, 1'b0);
			end else begin
				send_start(24'($urandom_range(1, 40)));
			end
		end
		if (link.ph != WAIT_START && $urandom_range(0, 3) == 0) send_event(OP_TIMEOUT);
	endtask

	task automatic write_config(logic [8:0] size_cap, logic [2:0] retries);
		cfg_valid <= 1'b1;
		cfg_index <= REG_OUT_BUFFER_SIZE;
		cfg_data <= size_cap;
		do begin
			@(posedge clk);
		end while (cfg_ready !== 1'b1);
		link.set_register(REG_OUT_BUFFER_SIZE, size_cap);
		cfg_index <= REG_RETRY_LIMIT;
		cfg_data <= {6'd0, retries};
		do begin
			@(posedge clk);
		end while (cfg_ready !== 1'b1);
		link.set_register(REG_RETRY_LIMIT, {6'd0, retries});
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_until_idle();
		push <= 1'b0;
		while (link.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int gap;
		int popped;
		popped = 0;
		@(posedge arst_n);
		forever begin
			if (popped % 60 == 0) rx_idle = ($urandom_range(0, 2) != 0);
			if (hold_request) begin
				hold_request = 1'b0;
				gap = HOLD_CYCLES;
			end else begin
				gap = rx_idle ? $urandom_range(0, 14) : 0;
			end
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do begin
				@(posedge clk);
			end while (empty !== 1'b0);
			link.check_result(result);
			popped++;
		end
	end

	initial begin
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
				stall = 0;
			end else begin
				stall++;
			end
		end
		$display("camera_image_packet_receiver_core_tb: errors");
		$finish;
	end

	initial begin
		int target;
		logic [8:0] size_caps [6];
		logic [2:0] retry_caps [6];
		link = new();
		size_caps = '{9'd506, 9'd1, 9'd506, 9'd40, 9'd0, 9'd12};
		retry_caps = '{3'd3, 3'd1, 3'd7, 3'd0, 3'd0, 3'd2};
		size_caps[4] = 9'($urandom_range(1, PAYLOAD_MAX));
		retry_caps[4] = 3'($urandom_range(1, 7));
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Events while idle are ignored; then a zero length, the largest length,
		// a restart, a clean one-packet image and a drained packet that is retried.
		send_event(OP_TIMEOUT);
		send_event(OP_IDLE);
		send_byte(8'hFF);
		send_start(24'd0);
		send_start(24'hFFFFFF);
		send_start(24'd2);
		send_packet(16'd2, 2, 1'b0);
		send_start(24'd5);
		send_packet(16'd0, 1, 1'b0);
		send_event(OP_IDLE);
		send_event(OP_TIMEOUT);

		for (int p = 0; p < 6; p++) begin
			wait_until_idle();
			write_config(size_caps[p], retry_caps[p]);
			if (p == 0) begin
				send_start(24'd3);
				send_packet(16'(PAYLOAD_MAX), 2, 1'b0);
				send_event(OP_TIMEOUT);
			end
			if (p == 2) hold_request = 1'b1;
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) run_transfer();
		end

		wait_until_idle();
		if (link.errors == 0 && link.awaited.size() == 0) begin
			$display("camera_image_packet_receiver_core_tb: clean");
		end else begin
			$display("camera_image_packet_receiver_core_tb: errors");
		end
		$finish;
	end

endmodule
